// ===== hdl/csr_to_hybrid_splitter_unit_assert.svh =====
// Assertion macros for the hybrid splitter
`ifndef CSR_TO_HYBRID_SPLITTER_UNIT_ASSERT_SVH
`define CSR_TO_HYBRID_SPLITTER_UNIT_ASSERT_SVH

// same-cycle implication
`define CSRHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csrhs assertion failed");

// next-cycle implication
`define CSRHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csrhs assertion failed");

`endif

// ===== hdl/csrhs_pkg.sv =====
package csrhs_pkg;

  localparam int WIDTH_W  = 6;
  localparam int STRIDE_W = 25;
  localparam int CFG_W    = 25;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W    = 24;
  localparam int COL_W    = 31;
  localparam int VAL_W    = 64;
  localparam int ADDR_W   = 29;

  localparam logic [CFG_IDX_W-1:0] CFG_ELL_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELL_STRIDE = 1'd1;

  localparam logic TGT_ELL = 1'b0;
  localparam logic TGT_COO = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic emit;
    logic close;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_write;
    logic last;
    logic slot_free;
  } dp_status_t;

endpackage

// ===== hdl/csrhs_ctrl.sv =====
module csrhs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  csrhs_pkg::dp_status_t status_i,
  output csrhs_pkg::ctl_cmd_t   cmd_o
);
  import csrhs_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_WORK;
        end
      end
      ST_WORK: begin
        if (status_i.has_write) begin
          if (status_i.slot_free) begin
            cmd_o.emit = 1'b1;
            if (status_i.last) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          // marker with nothing left to pad
          cmd_o.close = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/csrhs_datapath.sv =====
module csrhs_datapath #(
  parameter int MAX_ELL_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csrhs_pkg::ctl_cmd_t                 cmd_i,
  output csrhs_pkg::dp_status_t               status_o,
  input  logic                                cfg_we_i,
  input  logic [csrhs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [csrhs_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [csrhs_pkg::ROW_W-1:0]         row_index_i,
  input  logic [csrhs_pkg::COL_W-1:0]         col_index_i,
  input  logic [csrhs_pkg::VAL_W-1:0]         value_bits_i,
  input  logic                                entry_present_i,
  input  logic                                row_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                target_o,
  output logic [csrhs_pkg::ADDR_W-1:0]        address_o,
  output logic [csrhs_pkg::ROW_W-1:0]         row_out_o,
  output logic [csrhs_pkg::COL_W-1:0]         col_out_o,
  output logic [csrhs_pkg::VAL_W-1:0]         value_out_o,
  output logic                                last_write_o
);
  import csrhs_pkg::*;

  localparam int PosW  = $clog2(MAX_ELL_WIDTH + 1);
  localparam int WExtW = WIDTH_W + 1;
  localparam int ProdW = STRIDE_W + PosW;
  localparam logic [WExtW-1:0] MaxWidth = WExtW'(MAX_ELL_WIDTH);
  localparam logic [PosW-1:0]  PosMax   = PosW'(MAX_ELL_WIDTH);

  logic [WIDTH_W-1:0]  ell_width_q;
  logic [STRIDE_W-1:0] ell_stride_q;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [ADDR_W-1:0]   coo_q;
  logic                entry_pend_q;
  logic                ends_q;
  logic [ROW_W-1:0]    row_q;
  logic [COL_W-1:0]    col_q;
  logic [VAL_W-1:0]    val_q;
  logic                out_valid_q;

  logic [WExtW-1:0]    width_ext;
  logic [PosW-1:0]     width_eff;
  logic [PosW-1:0]     pos_sat;
  logic                pos_lt_width;
  logic                to_coo;
  logic                last_wr;
  logic [ProdW-1:0]    prod;
  logic [ADDR_W-1:0]   ell_addr;

  // register widths above the build limit act as the limit
  assign width_ext    = {1'b0, ell_width_q};
  assign width_eff    = (width_ext > MaxWidth) ? PosMax : PosW'(width_ext);
  assign pos_lt_width = pos_q < width_eff;
  assign pos_sat      = (pos_q == PosMax) ? pos_q : pos_q + PosW'(1);
  assign to_coo       = entry_pend_q && !pos_lt_width;
  assign last_wr      = !(ends_q && (pos_sat < width_eff));

  assign prod     = ProdW'(ell_stride_q) * ProdW'(pos_q);
  assign ell_addr = ADDR_W'(prod) + ADDR_W'(row_q);

  assign status_o.has_write = entry_pend_q || (ends_q && pos_lt_width);
  assign status_o.last      = last_wr;
  assign status_o.slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.emit) begin
      pos_d = (last_wr && ends_q) ? '0 : pos_sat;
    end else if (cmd_i.close && ends_q) begin
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ell_width_q  <= '0;
      ell_stride_q <= '0;
      pos_q        <= '0;
      coo_q        <= '0;
      entry_pend_q <= 1'b0;
      ends_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ELL_WIDTH:  ell_width_q  <= WIDTH_W'(cfg_data_i);
          CFG_ELL_STRIDE: ell_stride_q <= cfg_data_i;
          default: ;
        endcase
      end
      pos_q <= pos_d;
      if (cmd_i.accept) begin
        entry_pend_q <= entry_present_i;
        ends_q       <= row_end_i || !entry_present_i;
      end else if (cmd_i.emit) begin
        entry_pend_q <= 1'b0;
      end
      if (cmd_i.emit && to_coo && (coo_q != '1)) begin
        coo_q <= coo_q + ADDR_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      row_q <= row_index_i;
      col_q <= col_index_i;
      val_q <= value_bits_i;
    end
    if (cmd_i.emit) begin
      target_o     <= to_coo ? TGT_COO : TGT_ELL;
      address_o    <= to_coo ? coo_q : ell_addr;
      row_out_o    <= row_q;
      col_out_o    <= entry_pend_q ? col_q : '0;
      value_out_o  <= entry_pend_q ? val_q : '0;
      last_write_o <= last_wr;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/csr_to_hybrid_splitter_unit.sv =====
// A request is accepted in ST_IDLE; its writes are emitted from ST_WORK into the output
// register (one for an entry, plus one per padding slot at a row end, up to ell_width);
// the single output register loads one write per cycle while out_stall_i lets it drain.
// No new request is taken until the last write; a marker with no write closes in ST_WORK.
// Reset clears the config registers, row position and COO counter to zero.
module csr_to_hybrid_splitter_unit #(
  parameter int MAX_ELL_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [csrhs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [csrhs_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [csrhs_pkg::ROW_W-1:0]      row_index_i,
  input  logic [csrhs_pkg::COL_W-1:0]      col_index_i,
  input  logic [csrhs_pkg::VAL_W-1:0]      value_bits_i,
  input  logic                             entry_present_i,
  input  logic                             row_end_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             target_o,
  output logic [csrhs_pkg::ADDR_W-1:0]     address_o,
  output logic [csrhs_pkg::ROW_W-1:0]      row_out_o,
  output logic [csrhs_pkg::COL_W-1:0]      col_out_o,
  output logic [csrhs_pkg::VAL_W-1:0]      value_out_o,
  output logic                             last_write_o
);
  import csrhs_pkg::*;

  `include "csr_to_hybrid_splitter_unit_assert.svh"

  ctl_cmd_t   cmd;
  dp_status_t status;

  csrhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  csrhs_datapath #(
    .MAX_ELL_WIDTH (MAX_ELL_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .value_bits_i    (value_bits_i),
    .entry_present_i (entry_present_i),
    .row_end_i       (row_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .target_o        (target_o),
    .address_o       (address_o),
    .row_out_o       (row_out_o),
    .col_out_o       (col_out_o),
    .value_out_o     (value_out_o),
    .last_write_o    (last_write_o)
  );

  // one request in flight at a time
  `CSRHS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // final write of a request frees the input side
  `CSRHS_ASSERT_NEXT(a_idle_after_last, clk_i, rst_ni, cmd.emit && status.last, !in_stall_o)
  // no write is produced while the input side is open
  `CSRHS_ASSERT_NOW(a_no_emit_when_open, clk_i, rst_ni, !in_stall_o, !cmd.emit && !cmd.close)

endmodule

// ===== test/csr_to_hybrid_splitter_unit_test.sv =====
module csr_to_hybrid_splitter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csrhs_pkg::*;

  localparam int MAX_W = 32;

  typedef struct packed {
    logic              target;
    logic [ADDR_W-1:0] address;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [VAL_W-1:0]  value;
    logic              last;
  } hyb_write_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_ELL_WIDTH;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [ROW_W-1:0]     row_index_i = '0;
  logic [COL_W-1:0]     col_index_i = '0;
  logic [VAL_W-1:0]     value_bits_i = '0;
  logic                 entry_present_i = 1'b0;
  logic                 row_end_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 target_o;
  logic [ADDR_W-1:0]    address_o;
  logic [ROW_W-1:0]     row_out_o;
  logic [COL_W-1:0]     col_out_o;
  logic [VAL_W-1:0]     value_out_o;
  logic                 last_write_o;

  csr_to_hybrid_splitter_unit #(
    .MAX_ELL_WIDTH(MAX_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .value_bits_i   (value_bits_i),
    .entry_present_i(entry_present_i),
    .row_end_i      (row_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .target_o       (target_o),
    .address_o      (address_o),
    .row_out_o      (row_out_o),
    .col_out_o      (col_out_o),
    .value_out_o    (value_out_o),
    .last_write_o   (last_write_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the layout registers and the splitter state
  logic [WIDTH_W-1:0]  ell_width_q = '0;
  logic [STRIDE_W-1:0] ell_stride_q = '0;
  logic [31:0]         row_pos_q = '0;
  logic [ADDR_W-1:0]   coo_pos_q = '0;

  hyb_write_t  writes_due[$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int unsigned hold_cycles = 0;
  logic [ROW_W-1:0] cur_row = '0;

  function automatic logic [ADDR_W-1:0] ell_slot(logic [ROW_W-1:0] row, logic [31:0] k);
    logic [63:0] sum;
    sum = 64'(row) + 64'(ell_stride_q) * 64'(k);
    return sum[ADDR_W-1:0];
  endfunction

  task automatic predict_writes(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                                input logic [VAL_W-1:0] value, input logic present,
                                input logic row_end);
    logic [31:0] slots;
    logic [31:0] pos_after;
    logic [31:0] k;
    logic        closes;
    logic        pads;
    slots = (ell_width_q > MAX_W) ? MAX_W : 32'(ell_width_q);
    closes = row_end || !present;
    pos_after = row_pos_q;
    if (present && row_pos_q != '1) pos_after = row_pos_q + 1;
    pads = closes && (pos_after < slots);
    if (present) begin
      if (row_pos_q < slots) begin
        writes_due.push_back(hyb_write_t'{TGT_ELL, ell_slot(row, row_pos_q), row, col,
                                          value, !pads});
      end else begin
        writes_due.push_back(hyb_write_t'{TGT_COO, coo_pos_q, row, col, value, !pads});
        if (coo_pos_q != '1) coo_pos_q = coo_pos_q + 1;
      end
    end
    row_pos_q = pos_after;
    if (closes) begin
      for (k = row_pos_q; k < slots; k++) begin
        writes_due.push_back(hyb_write_t'{TGT_ELL, ell_slot(row, k), row, '0, '0,
                                          k == slots - 1});
      end
      row_pos_q = '0;
    end
  endtask

  // called at a rising edge; returns at the edge that accepts the request
  task automatic send_request(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                              input logic [VAL_W-1:0] value, input logic present,
                              input logic row_end);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    row_index_i     <= row;
    col_index_i     <= col;
    value_bits_i    <= value;
    entry_present_i <= present;
    row_end_i       <= row_end;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_writes(row, col, value, present, row_end);
    items_sent++;
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (writes_due.size() != 0) @(posedge clk_i);
    // a marker with no write may still be in flight
    repeat (4) @(posedge clk_i);
  endtask

  // width goes in with junk above its 6 bits
  task automatic set_layout(input logic [WIDTH_W-1:0] width, input logic [STRIDE_W-1:0] stride);
    logic [CFG_W-1:0] wdata;
    wdata = {(CFG_W-WIDTH_W)'($urandom()), width};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ELL_WIDTH;
    cfg_data_i  <= wdata;
    @(posedge clk_i);
    cfg_index_i <= CFG_ELL_STRIDE;
    cfg_data_i  <= stride;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ell_width_q  = wdata[WIDTH_W-1:0];
    ell_stride_q = stride;
  endtask

  function automatic logic [COL_W-1:0] rand_col();
    return COL_W'($urandom());
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    return {$urandom(), $urandom()};
  endfunction

  task automatic next_row();
    if ($urandom_range(0, 15) == 0) cur_row = ROW_W'($urandom());
    else cur_row = cur_row + ROW_W'($urandom_range(1, 3));
  endtask

  // mostly well-formed rows, some stray entries and rows cut short by a marker
  task automatic run_random(input int unsigned count);
    int unsigned start;
    int unsigned slots;
    int unsigned nnz;
    int unsigned kind;
    int unsigned i;
    start = items_sent;
    slots = (ell_width_q > MAX_W) ? MAX_W : ell_width_q;
    while (items_sent - start < count) begin
      kind = $urandom_range(0, 9);
      next_row();
      if (kind <= 7) begin
        nnz = $urandom_range(0, slots + 3);
        if (nnz == 0) begin
          send_request(cur_row, rand_col(), rand_value(), 1'b0, 1'($urandom()));
        end else begin
          for (i = 0; i < nnz; i++)
            send_request(cur_row, rand_col(), rand_value(), 1'b1, i == nnz - 1);
        end
      end else if (kind == 8) begin
        send_request(ROW_W'($urandom()), rand_col(), rand_value(), 1'b1, 1'($urandom()));
      end else begin
        nnz = $urandom_range(1, 3);
        for (i = 0; i < nnz; i++)
          send_request(cur_row, rand_col(), rand_value(), 1'b1, 1'b0);
        if ($urandom_range(0, 1) == 1) next_row();
        send_request(cur_row, rand_col(), rand_value(), 1'b0, 1'($urandom()));
      end
    end
  endtask

  // layout after reset: everything goes to COO, markers produce nothing
  task automatic test_reset_layout();
    send_request('0, '0, '0, 1'b1, 1'b1);
    send_request(24'd1, rand_col(), rand_value(), 1'b0, 1'b1);
    send_request(24'd2, '1, '1, 1'b1, 1'b0);
    send_request(24'd2, rand_col(), rand_value(), 1'b1, 1'b1);
    send_request(24'd3, rand_col(), rand_value(), 1'b0, 1'b0);
    quiesce();
  endtask

  // max stride with the max row index gives the widest slot addresses; marker closes a row mid-way
  task automatic test_wrapped_stride();
    set_layout(6'd3, '1);
    send_request('1, '1, '1, 1'b1, 1'b0);
    send_request('1, rand_col(), rand_value(), 1'b0, 1'b0);
    send_request(24'd5, rand_col(), rand_value(), 1'b1, 1'b0);
    send_request(24'd5, rand_col(), rand_value(), 1'b1, 1'b0);
    send_request(24'd5, rand_col(), rand_value(), 1'b1, 1'b0);
    send_request(24'd5, rand_col(), rand_value(), 1'b1, 1'b1);
    quiesce();
  endtask

  // width above the maximum acts as the maximum
  task automatic test_clamped_width();
    set_layout(6'd63, 25'd1);
    send_request(24'd10, rand_col(), rand_value(), 1'b0, 1'b1);
    send_request(24'd11, rand_col(), rand_value(), 1'b1, 1'b1);
    quiesce();
    set_layout(6'd33, 25'd24);
    send_request(24'd12, rand_col(), rand_value(), 1'b0, 1'b0);
    quiesce();
    set_layout(6'd32, 25'h1000000);
    send_request(24'd13, '0, '0, 1'b1, 1'b1);
    send_request(24'h800000, '1, '1, 1'b1, 1'b0);
    send_request(24'h800000, rand_col(), rand_value(), 1'b0, 1'b1);
    quiesce();
  endtask

  task automatic test_random_layouts();
    set_layout(6'd1, 25'd1000);
    run_random(60);
    quiesce();
    set_layout(6'd4, 25'd4096);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(60);
    quiesce();
    set_layout(6'd8, '1);
    tx_idle = 1'b1;
    run_random(60);
    quiesce();
    set_layout(6'd0, 25'd77);
    rx_idle = 1'b1;
    run_random(50);
    quiesce();
    set_layout(6'd32, 25'h1000000);
    tx_idle = 1'b0;
    run_random(50);
    quiesce();
    set_layout(6'd40, STRIDE_W'($urandom()));
    tx_idle = 1'b1;
    run_random(60);
    quiesce();
    set_layout(WIDTH_W'($urandom_range(0, 63)), STRIDE_W'($urandom()));
    run_random(40);
    quiesce();
  endtask

  // receiver holds off while the sender keeps pushing, so the input stalls
  task automatic test_backpressure();
    set_layout(6'd2, 25'd50);
    tx_idle = 1'b0;
    hold_cycles = 400;
    run_random(40);
    quiesce();
    tx_idle = 1'b1;
  endtask

  task automatic note_failure(input string what, input hyb_write_t exp, input hyb_write_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: exp tgt=%0d addr=%h row=%h col=%h val=%h last=%0d",
               $realtime, what, exp.target, exp.address, exp.row, exp.col, exp.value,
               exp.last);
      $display("%0t %s: got tgt=%0d addr=%h row=%h col=%h val=%h last=%0d",
               $realtime, what, got.target, got.address, got.row, got.col, got.value,
               got.last);
    end
  endtask

  always @(posedge clk_i) begin
    hyb_write_t got;
    hyb_write_t exp;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = hyb_write_t'{target_o, address_o, row_out_o, col_out_o, value_out_o, last_write_o};
      if (writes_due.size() == 0) begin
        note_failure("unexpected write", '0, got);
      end else begin
        exp = writes_due.pop_front();
        if (got.target !== exp.target || got.address !== exp.address ||
            got.row !== exp.row || got.col !== exp.col || got.value !== exp.value ||
            got.last !== exp.last)
          note_failure("write mismatch", exp, got);
      end
    end
  end

  // receiver: random stall before each write, or one long hold on request
  initial begin
    int unsigned stall_n;
    forever begin
      stall_n = rx_idle ? $urandom_range(0, 5) : 0;
      if (hold_cycles > 0) begin
        stall_n = hold_cycles;
        hold_cycles = 0;
      end
      if (stall_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_layout();
    test_wrapped_stride();
    test_clamped_width();
    test_random_layouts();
    test_backpressure();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && writes_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
